/* rtl/wcb_pkg.sv */
`timescale 1ns / 1ps
package wcb_pkg;

  localparam int SLOTS_DEF = 16;

  // free-slot search width per cycle
  localparam int SCAN_W   = 16;
  localparam int SCAN_LOG = $clog2(SCAN_W);

  localparam int KIND_W   = 3;
  localparam int HANDLE_W = 4;
  localparam int GEN_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_CREATE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STEP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_WRAPS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_VALUE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RD_SET   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_STALE   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [HANDLE_W-1:0]      handle;
    logic [GEN_W-1:0]         gen_tag;
    logic signed [DATA_W-1:0] upper_bound;
    logic signed [DATA_W-1:0] lower_bound;
    logic signed [DATA_W-1:0] step_size;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [HANDLE_W-1:0]      handle_out;
    logic [GEN_W-1:0]         gen_out;
    logic signed [DATA_W-1:0] value_out;
    logic [DATA_W-1:0]        wraps_out;
    logic signed [DATA_W-1:0] upper_out;
    logic signed [DATA_W-1:0] lower_out;
    logic signed [DATA_W-1:0] step_out;
  } result_t;

  // classified word held in the queue between front and back
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     is_create;
    logic                     is_delete;
    logic                     bad;
    logic [HANDLE_W-1:0]      handle;
    logic [GEN_W-1:0]         gen_tag;
    logic signed [DATA_W-1:0] upper_bound;
    logic signed [DATA_W-1:0] lower_bound;
    logic signed [DATA_W-1:0] step_size;
  } op_t;

endpackage

/* rtl/wcb_front.sv */
`timescale 1ns / 1ps
module wcb_front import wcb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  hold,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  q_valid,
  input  logic  q_pop,
  output op_t   q_head
);

  op_t        fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_t        op_in;

  always_comb begin
    op_in             = '0;
    op_in.kind        = item.kind;
    op_in.handle      = item.handle;
    op_in.gen_tag     = item.gen_tag;
    op_in.upper_bound = item.upper_bound;
    op_in.lower_bound = item.lower_bound;
    op_in.step_size   = item.step_size;
    unique case (item.kind) inside
      KIND_CREATE: op_in.is_create = 1'b1;
      KIND_DELETE: op_in.is_delete = 1'b1;
      KIND_NONE:   op_in.bad       = 1'b1;
      default:     op_in.bad       = 1'b0;
    endcase
  end

  assign item_stall = hold || (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != 2'd0);
  assign q_head     = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/wcb_back.sv */
`timescale 1ns / 1ps
module wcb_back import wcb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  output logic    clearing,
  input  logic    q_valid,
  output logic    q_pop,
  input  op_t     q_head,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int XW   = (CW > HANDLE_W) ? CW : HANDLE_W;
  localparam int NGRP = (SLOTS + SCAN_W - 1) / SCAN_W;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int AW   = NGRP * SCAN_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  typedef struct packed {
    logic [GEN_W-1:0]         gen;
    logic [DATA_W-1:0]        wraps;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] upper;
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] step;
  } slot_rec_t;

  slot_rec_t slot_mem [SLOTS];
  slot_rec_t rdata;
  logic      mem_we;
  slot_rec_t mem_wdata;
  logic [SW-1:0] mem_waddr;

  logic [2:0]       state;
  op_t              cur;
  logic [SW-1:0]    slot;
  logic [SW-1:0]    clr_idx;
  logic [GW-1:0]    grp;
  logic [CW-1:0]    used_count;
  logic [CW-1:0]    freed_count;
  logic [SLOTS-1:0] active;
  result_t          res;
  result_t          idle_res;
  logic signed [DATA_W-1:0] wv;
  logic [DATA_W-1:0]        ww;

  // handle check
  logic [XW-1:0] h_x;
  logic [SW-1:0] h_slot;
  logic          h_ok;

  // free-slot search over one group per cycle
  logic [AW-1:0]       act_pad;
  logic [SCAN_W-1:0]   grp_act;
  logic [SCAN_W-1:0]   grp_free;
  logic [SCAN_LOG-1:0] scan_pos;
  logic                scan_found;
  logic [SW-1:0]       scan_slot;
  int                  base;

  // step datapath
  logic                     above;
  logic                     below;
  logic signed [DATA_W-1:0] wrapped_val;
  logic [DATA_W-1:0]        wraps_upd;
  logic [DATA_W:0]          sum;
  logic signed [DATA_W-1:0] sat_val;
  logic [GEN_W-1:0]         gen_inc;
  logic                     gen_match;
  logic                     out_free;

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !result_valid || !result_stall;

  assign h_x    = XW'(q_head.handle);
  assign h_slot = h_x[SW-1:0];
  assign h_ok   = !q_head.bad && (h_x < XW'(used_count)) && active[h_slot];

  // result word as known at pop: full, invalid handle and delete are final here
  always_comb begin
    idle_res = '0;
    if (q_head.is_create) begin
      if ((freed_count == '0) && (used_count == CW'(SLOTS))) begin
        idle_res.status = ST_FULL;
      end
    end else if (!h_ok) begin
      idle_res.status = ST_INVALID;
    end else if (q_head.is_delete) begin
      idle_res.handle_out = q_head.handle;
    end
  end

  always_comb begin
    act_pad = AW'(active);
    base    = int'(grp) * SCAN_W;
    grp_act = act_pad[base +: SCAN_W];
    for (int i = 0; i < SCAN_W; i++) begin
      grp_free[i] = !grp_act[i] && ((base + i) < int'(used_count));
    end
    scan_pos = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (grp_free[i]) begin
        scan_pos = SCAN_LOG'(i);
      end
    end
    scan_found = |grp_free;
    scan_slot  = SW'(base + int'(scan_pos));
  end

  always_comb begin
    above       = rdata.value > rdata.upper;
    below       = rdata.value < rdata.lower;
    wrapped_val = above ? rdata.lower : (below ? rdata.upper : rdata.value);
    wraps_upd   = ((above || below) && (rdata.wraps != '1)) ? rdata.wraps + 32'd1
                                                            : rdata.wraps;
    sum         = {wv[DATA_W-1], wv} + {rdata.step[DATA_W-1], rdata.step};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sat_val = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_val = sum[DATA_W-1:0];
    end
    gen_inc   = rdata.gen + 16'd1;
    gen_match = (cur.gen_tag == rdata.gen);
  end

  // single write port: clear sweep, create, reset-to-min, step write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_EXEC: begin
        if (cur.is_create) begin
          mem_we          = 1'b1;
          mem_wdata.gen   = gen_inc;
          mem_wdata.wraps = '0;
          mem_wdata.value = '0;
          mem_wdata.upper = cur.upper_bound;
          mem_wdata.lower = cur.lower_bound;
          mem_wdata.step  = cur.step_size;
        end else if (gen_match && (cur.kind == KIND_RESET)) begin
          mem_we          = 1'b1;
          mem_wdata.value = rdata.lower;
        end
      end
      S_ADD: begin
        mem_we          = 1'b1;
        mem_wdata.value = sat_val;
        mem_wdata.wraps = ww;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= slot_mem[slot];
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur <= q_head;
          res <= idle_res;
          if (q_head.is_create) begin
            if ((freed_count == '0) && (used_count != CW'(SLOTS))) begin
              slot <= used_count[SW-1:0];
            end
          end else if (h_ok && !q_head.is_delete) begin
            slot <= h_slot;
          end
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          slot <= scan_slot;
        end
      end
      S_EXEC: begin
        if (cur.is_create) begin
          res.handle_out <= HANDLE_W'(slot);
          res.gen_out    <= gen_inc;
        end else if (!gen_match) begin
          res.status <= ST_STALE;
        end else begin
          case (cur.kind)
            KIND_STEP: begin
              wv <= wrapped_val;
              ww <= wraps_upd;
            end
            KIND_RD_WRAPS: res.wraps_out <= rdata.wraps;
            KIND_RD_VALUE: res.value_out <= rdata.value;
            KIND_RD_SET: begin
              res.upper_out <= rdata.upper;
              res.lower_out <= rdata.lower;
              res.step_out  <= rdata.step;
            end
            default: res.value_out <= '0;
          endcase
        end
      end
      S_ADD: res.value_out <= wv;
      S_FINISH: begin
        if (out_free) begin
          result <= res;
        end
      end
      default: res <= res;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      grp          <= '0;
      used_count   <= '0;
      freed_count  <= '0;
      active       <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_idx == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + SW'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            if (q_head.is_create) begin
              if (freed_count != '0) begin
                grp   <= '0;
                state <= S_SCAN;
              end else if (used_count == CW'(SLOTS)) begin
                state <= S_FINISH;
              end else begin
                state <= S_READ;
              end
            end else if (!h_ok) begin
              state <= S_FINISH;
            end else if (q_head.is_delete) begin
              active[h_slot] <= 1'b0;
              freed_count    <= freed_count + CW'(1);
              state          <= S_FINISH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SCAN: begin
          if (scan_found) begin
            state <= S_READ;
          end else begin
            grp <= grp + GW'(1);
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (cur.is_create) begin
            active[slot] <= 1'b1;
            if (freed_count != '0) begin
              freed_count <= freed_count - CW'(1);
            end else begin
              used_count <= used_count + CW'(1);
            end
            state <= S_FINISH;
          end else if (gen_match && (cur.kind == KIND_STEP)) begin
            state <= S_ADD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_ADD: state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/wrapping_counter_bank.sv */
`timescale 1ns / 1ps
// Bank of SLOTS wrapping Q16.16 counters, addressed by handle.
// Channels: one input word per operation (item_valid / item_stall / item) and
// exactly one result word per input word (result_valid / result_stall / result),
// in order. A word moves on a clock edge with valid high and stall low.
// Structure: the front classifies incoming words into a two-entry queue; the
// back pops one word at a time and does a read-modify-write of the slot record
// in a slot memory with one read and one write port, then parks the result in
// an output register. The back steps each word through IDLE, READ, EXEC and
// FINISH, with ADD before FINISH for a step that passes its checks; delete,
// full and invalid-handle words go from IDLE straight to FINISH. Create that
// reuses a deleted slot first passes SCAN, searching one 16-slot group at a
// time for the lowest free slot. The back pops no new word until the last has
// left FINISH, paced by the memory read, evaluate and write-back sequence.
// Reset: synchronous; afterwards the back sweeps the slot memory to zero, one
// slot at a time, with item_stall high the whole time.
// A stalled receiver holds the result register; the back waits with the next
// result, and the front keeps taking words until its queue is full.
module wrapping_counter_bank import wcb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic clearing;
  logic q_valid;
  logic q_pop;
  op_t  q_head;

  // front: decode kind, buffer words
  wcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_head     (q_head)
  );

  // back: slot memory, allocation, counter arithmetic, result register
  wcb_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_head       (q_head),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* rtl/wcb_checker.sv */
`timescale 1ns / 1ps
module wcb_checker import wcb_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && item_stall)
    else $error("block not quiet after reset");

  // error results carry nothing but the status
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_OK) |->
      (result.handle_out == '0) && (result.gen_out == '0) &&
      (result.value_out == '0) && (result.wraps_out == '0) &&
      (result.upper_out == '0) && (result.lower_out == '0) &&
      (result.step_out == '0))
    else $error("error result carries data");

  // a nonzero generation only comes from create, which reports no data
  a_create_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_OK) && (result.gen_out != '0) |->
      (result.value_out == '0) && (result.wraps_out == '0) &&
      (result.upper_out == '0) && (result.lower_out == '0) &&
      (result.step_out == '0))
    else $error("create result carries data");

endmodule

bind wrapping_counter_bank wcb_checker u_wcb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

/* sim/tb_wrapping_counter_bank.sv */
`timescale 1ns / 1ps
module tb_wrapping_counter_bank;
  import wcb_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int PLAN        = 0;     // bank copy the stimulus builder walks ahead with
  localparam int LIVE        = 1;     // bank copy advanced on each accepted word
  localparam int LONG_HOLD   = 200;   // receiver back-pressure stretch, in cycles
  localparam int IDLE_LIMIT  = 4000;  // cycles with no word moving before giving up
  localparam int TAIL_CYCLES = 20;    // settle time after the last result
  localparam int RANDOM_OPS  = 750;

  localparam longint S32_MAX = longint'(32'sh7fffffff);
  localparam longint S32_MIN = longint'(32'sh80000000);

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_e;

  // one planned input word plus how the sender treats it
  typedef struct packed {
    item_t      word;
    logic [3:0] gap;            // idle cycles before offering it
    logic       hold_for_drain; // offer only once no result is outstanding
  } tx_slot_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // counter bank state, two copies: PLAN and LIVE
  logic signed [DATA_W-1:0] m_value [2][SLOTS];
  logic signed [DATA_W-1:0] m_upper [2][SLOTS];
  logic signed [DATA_W-1:0] m_lower [2][SLOTS];
  logic signed [DATA_W-1:0] m_step  [2][SLOTS];
  logic [DATA_W-1:0]        m_wraps [2][SLOTS];
  logic [GEN_W-1:0]         m_gen   [2][SLOTS];
  logic                     m_active[2][SLOTS];
  int                       m_used  [2];
  int                       m_freed [2];

  tx_slot_t word_plan[$];       // words waiting to be offered
  result_t  results_due[$];     // predicted results, oldest first

  // sender state
  tx_slot_t tx_cur;
  logic     tx_have = 1'b0;
  int       tx_wait = 0;
  logic     tx_calm = 1'b0;
  logic     tx_rush = 1'b0;
  int       planned = 0;

  // receiver state
  int   rx_count = 0;
  int   rx_wait = 0;
  int   rx_hold = 0;
  logic rx_calm = 1'b0;
  int   soak_lo = 0;
  int   soak_hi = 0;
  int   hold_at = -1;

  int mismatches = 0;
  int idle_cycles = 0;

  wrapping_counter_bank #(.SLOTS(SLOTS)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bank behavior
  // ---------------------------------------------------------------------------

  task automatic bank_clear(input int c);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      m_value[c][i]  = '0;
      m_upper[c][i]  = '0;
      m_lower[c][i]  = '0;
      m_step[c][i]   = '0;
      m_wraps[c][i]  = '0;
      m_gen[c][i]    = '0;
      m_active[c][i] = 1'b0;
    end
    m_used[c]  = 0;
    m_freed[c] = 0;
  endtask

  // Applies one word to bank copy c and returns the result it produces.
  function automatic result_t bank_apply(input int c, input item_t w);
    result_t                  r;
    int                       m;
    int                       i;
    int                       h;
    logic                     found;
    longint                   total;
    logic signed [DATA_W-1:0] v;
    r = '0;
    h = int'(w.handle);

    if (w.kind == KIND_CREATE) begin
      // lowest deleted slot first, else the next fresh one
      found = 1'b0;
      m = m_used[c];
      if (m_freed[c] != 0) begin
        for (i = 0; i < m_used[c]; i++) begin
          if (!found && !m_active[c][i]) begin
            found = 1'b1;
            m = i;
          end
        end
      end
      if (found) begin
        m_freed[c]--;
      end else if (m_used[c] >= SLOTS) begin
        r.status = ST_FULL;
        return r;
      end else begin
        m_used[c]++;
      end
      m_active[c][m] = 1'b1;
      m_gen[c][m]    = m_gen[c][m] + 16'd1;   // wraps past 0xFFFF
      m_wraps[c][m]  = '0;
      m_value[c][m]  = '0;
      m_upper[c][m]  = w.upper_bound;
      m_lower[c][m]  = w.lower_bound;
      m_step[c][m]   = w.step_size;
      r.status       = ST_OK;
      r.handle_out   = m[HANDLE_W-1:0];
      r.gen_out      = m_gen[c][m];
      return r;
    end

    if (w.kind == KIND_NONE || h >= m_used[c] || !m_active[c][h]) begin
      r.status = ST_INVALID;
      return r;
    end

    // delete skips the generation check
    if (w.kind == KIND_DELETE) begin
      m_active[c][h] = 1'b0;
      m_freed[c]++;
      r.status     = ST_OK;
      r.handle_out = w.handle;
      return r;
    end

    if (w.gen_tag != m_gen[c][h]) begin
      r.status = ST_STALE;
      return r;
    end

    r.status = ST_OK;
    case (w.kind)
      KIND_STEP: begin
        v = m_value[c][h];
        if (v > m_upper[c][h]) begin
          v = m_lower[c][h];
          if (m_wraps[c][h] != '1) m_wraps[c][h] = m_wraps[c][h] + 1;
        end else if (v < m_lower[c][h]) begin
          v = m_upper[c][h];
          if (m_wraps[c][h] != '1) m_wraps[c][h] = m_wraps[c][h] + 1;
        end
        r.value_out = v;
        total = longint'(v) + longint'(m_step[c][h]);
        if (total > S32_MAX) v = 32'sh7fffffff;
        else if (total < S32_MIN) v = 32'sh80000000;
        else v = total[DATA_W-1:0];
        m_value[c][h] = v;
      end
      KIND_RD_WRAPS: r.wraps_out = m_wraps[c][h];
      KIND_RD_VALUE: r.value_out = m_value[c][h];
      KIND_RESET:    m_value[c][h] = m_lower[c][h];
      default: begin
        r.upper_out = m_upper[c][h];
        r.lower_out = m_lower[c][h];
        r.step_out  = m_step[c][h];
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic item_t op_word(input logic [KIND_W-1:0] k, input int h,
                                    input logic [GEN_W-1:0] g,
                                    input logic signed [DATA_W-1:0] up,
                                    input logic signed [DATA_W-1:0] lo,
                                    input logic signed [DATA_W-1:0] st);
    item_t w;
    w.kind        = k;
    w.handle      = h[HANDLE_W-1:0];
    w.gen_tag     = g;
    w.upper_bound = up;
    w.lower_bound = lo;
    w.step_size   = st;
    return w;
  endfunction

  // Queues a word and advances the PLAN copy so later words can aim at live
  // handles with the right generation.
  task automatic plan_word(input item_t w, input logic drain);
    tx_slot_t e;
    void'(bank_apply(PLAN, w));
    if (planned % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    planned++;
    e.word           = w;
    e.gap            = (tx_rush || tx_calm) ? 4'd0 : 4'($urandom_range(0, 13));
    e.hold_for_drain = drain;
    word_plan.push_back(e);
  endtask

  function automatic int pick_live();
    int cand[$];
    int i;
    for (i = 0; i < SLOTS; i++)
      if (m_active[PLAN][i]) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  initial begin : stimulus
    int                       n;
    int                       h;
    int                       r;
    int                       cut;
    int                       lo_i;
    int                       span_i;
    int                       st_i;
    int                       pct_create;
    int                       pct_delete;
    mix_e                     mix;
    logic [KIND_W-1:0]        k;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] st;
    logic [KIND_W-1:0]        body_kinds [8];

    body_kinds = '{KIND_STEP, KIND_STEP, KIND_STEP, KIND_STEP,
                   KIND_RD_WRAPS, KIND_RD_VALUE, KIND_RESET, KIND_RD_SET};
    bank_clear(PLAN);

    // --- directed ---
    // empty bank: any handle is out of range; reserved kind is invalid
    plan_word(op_word(KIND_STEP, 0, 16'd0, '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_NONE, 0, 16'd0, '0, '0, '0), 1'b0);

    // slot 0: max 3.0, min -1.5, incr 1.25 -> 0, 1.25, 2.5, then wrap to min
    plan_word(op_word(KIND_CREATE, 0, 16'd0, 32'sd196608, -32'sd98304, 32'sd81920), 1'b0);
    repeat (4) plan_word(op_word(KIND_STEP, 0, m_gen[PLAN][0], '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_RD_WRAPS, 0, m_gen[PLAN][0], '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_RD_VALUE, 0, m_gen[PLAN][0], '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_RD_SET, 0, m_gen[PLAN][0], '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_STEP, 0, m_gen[PLAN][0] + 16'd1, '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_RESET, 0, m_gen[PLAN][0], '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_RD_VALUE, 0, m_gen[PLAN][0], '0, '0, '0), 1'b0);

    // slot 1: full range, max increment -> saturates high
    plan_word(op_word(KIND_CREATE, 0, 16'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff),
              1'b0);
    repeat (2) plan_word(op_word(KIND_STEP, 1, m_gen[PLAN][1], '0, '0, '0), 1'b0);

    // slot 2: 0 above max -1.0 wraps to MIN, then MIN increment saturates low
    plan_word(op_word(KIND_CREATE, 0, 16'd0, -32'sd65536, 32'sh80000000, 32'sh80000000),
              1'b0);
    repeat (2) plan_word(op_word(KIND_STEP, 2, m_gen[PLAN][2], '0, '0, '0), 1'b0);

    // slot 3: 0 below min 5.0 wraps to max 10.0, decrements by 3.0 and wraps again
    plan_word(op_word(KIND_CREATE, 0, 16'd0, 32'sd655360, 32'sd327680, -32'sd196608), 1'b0);
    repeat (3) plan_word(op_word(KIND_STEP, 3, m_gen[PLAN][3], '0, '0, '0), 1'b0);

    // delete takes any tag; second delete and a never-used handle are invalid
    plan_word(op_word(KIND_DELETE, 1, 16'hBEEF, '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_DELETE, 1, m_gen[PLAN][1], '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_RD_VALUE, 15, 16'd0, '0, '0, '0), 1'b0);
    // reuse of the freed slot
    plan_word(op_word(KIND_CREATE, 0, 16'd0, 32'sd65536, -32'sd65536, 32'sd32768), 1'b0);

    // --- back-to-back delete/create burst on slot 0 ---
    tx_rush = 1'b1;
    soak_lo = word_plan.size();
    repeat (20) begin
      plan_word(op_word(KIND_DELETE, 0, 16'd0, '0, '0, '0), 1'b0);
      plan_word(op_word(KIND_CREATE, 0, 16'd0, 32'sd131072, -32'sd131072, 32'sd65536),
                1'b0);
    end
    soak_hi = word_plan.size();
    tx_rush = 1'b0;
    // a tag from before the burst is stale
    plan_word(op_word(KIND_STEP, 0, m_gen[PLAN][0] - 16'd20, '0, '0, '0), 1'b0);
    plan_word(op_word(KIND_RD_SET, 0, m_gen[PLAN][0], '0, '0, '0), 1'b0);

    hold_at = soak_hi + 100;

    // --- random: phases lean toward filling, draining or a blend ---
    mix = MIX_FILL;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) mix = (n == 0) ? MIX_FILL : mix_e'($urandom_range(0, 2));
      case (mix)
        MIX_FILL:  begin pct_create = 50; pct_delete = 3;  end
        MIX_DRAIN: begin pct_create = 5;  pct_delete = 30; end
        default:   begin pct_create = 15; pct_delete = 8;  end
      endcase

      // bounds for a create, if one is picked
      cut = $urandom_range(0, 7);
      if (cut == 0) begin
        up = $urandom;
        lo = $urandom;
        st = $urandom;
      end else if (cut == 1) begin
        up = 32'sh7fffffff;
        lo = 32'sh80000000;
        st = $urandom;
      end else begin
        lo_i   = int'($urandom_range(0, 1310720)) - 1310720;  // -20.0 .. 0
        span_i = int'($urandom_range(0, 1966080));            // 0 .. 30.0
        st_i   = int'($urandom_range(0, 524288));             // 0 .. 8.0
        if ($urandom_range(0, 1) == 1) st_i = -st_i;
        lo = lo_i;
        up = lo_i + span_i;
        st = st_i;
      end

      r = $urandom_range(0, 99);
      h = pick_live();
      if (r < 15) begin
        // noise: any kind, handle, tag and payload
        plan_word(op_word(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 15),
                          GEN_W'($urandom), $urandom, $urandom, $urandom), 1'b0);
      end else if (r < 22 && h >= 0) begin
        // live handle, wrong generation
        k = body_kinds[$urandom_range(0, 7)];
        plan_word(op_word(k, h, m_gen[PLAN][h] ^ GEN_W'($urandom_range(1, 65535)),
                          '0, '0, '0), 1'b0);
      end else begin
        r = $urandom_range(0, 99);
        if (h < 0 || r < pct_create) k = KIND_CREATE;
        else if (r < pct_create + pct_delete) k = KIND_DELETE;
        else k = body_kinds[$urandom_range(0, 7)];
        if (h < 0) h = 0;
        plan_word(op_word(k, h, m_gen[PLAN][h], up, lo, st), (n % 150 == 149));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (word_plan.size() != 0 || tx_have || item_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: offers planned words, predicts on each accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : send_words
    logic nx_valid;
    if (rst) begin
      bank_clear(LIVE);
      item_valid <= 1'b0;
      tx_have = 1'b0;
      tx_wait = 0;
    end else begin
      nx_valid = item_valid;
      if (item_valid && !item_stall) begin
        results_due.push_back(bank_apply(LIVE, item));
        nx_valid = 1'b0;
      end
      if (!nx_valid && !tx_have && word_plan.size() != 0) begin
        tx_cur  = word_plan.pop_front();
        tx_have = 1'b1;
        tx_wait = int'(tx_cur.gap);
      end
      if (!nx_valid && tx_have) begin
        if (tx_wait != 0) begin
          tx_wait--;
        end else if (!tx_cur.hold_for_drain || results_due.size() == 0) begin
          // a drain word waits until the block has answered everything
          item     <= tx_cur.word;
          nx_valid = 1'b1;
          tx_have  = 1'b0;
        end
      end
      item_valid <= nx_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted result, draws its stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : take_results
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: st=%0d h=%0d g=%0d v=%0d",
                     $realtime, result.status, result.handle_out, result.gen_out,
                     result.value_out);
        end else begin
          want = results_due.pop_front();
          if (result.status !== want.status || result.handle_out !== want.handle_out ||
              result.gen_out !== want.gen_out || result.value_out !== want.value_out ||
              result.wraps_out !== want.wraps_out || result.upper_out !== want.upper_out ||
              result.lower_out !== want.lower_out || result.step_out !== want.step_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word %0d mismatch", $realtime, rx_count);
              $display("  want st=%0d h=%0d g=%0d v=%0d w=%0d up=%0d lo=%0d inc=%0d",
                       want.status, want.handle_out, want.gen_out, want.value_out,
                       want.wraps_out, want.upper_out, want.lower_out, want.step_out);
              $display("  got  st=%0d h=%0d g=%0d v=%0d w=%0d up=%0d lo=%0d inc=%0d",
                       result.status, result.handle_out, result.gen_out, result.value_out,
                       result.wraps_out, result.upper_out, result.lower_out, result.step_out);
            end
          end
        end
        rx_count++;
        if (rx_count % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        // long hold: block fills up and stalls its input
        if (rx_count == hold_at) rx_hold = LONG_HOLD;
        if (rx_count >= soak_lo && rx_count < soak_hi) rx_wait = 0;
        else rx_wait = rx_calm ? 0 : $urandom_range(0, 13);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        result_stall <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no word moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
